// File: rtl/base64_stream_encoder_defines.svh
// assertion macros for the base64 stream encoder
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define B64E_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define B64E_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/b64enc_pkg.sv
// shared types, constants and the character table of the base64 encoder
`default_nettype none

package b64enc_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] PAD_CHAR    = 8'h3D;
  localparam logic [5:0] SEXTET_MASK = 6'h3F;

  // one 24-bit group with its padding count and end-of-message flag
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  n_pad;
    logic        fin;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v & SEXTET_MASK};
    priority if (w < 8'd26) begin
      c = 8'h41 + w;
    end else if (w < 8'd52) begin
      c = 8'h61 + w - 8'd26;
    end else if (w < 8'd62) begin
      c = 8'h30 + w - 8'd52;
    end else if (w == 8'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/b64enc_byte_if.sv
// byte channel: one raw message byte per word
`default_nettype none

interface b64enc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/b64enc_char_if.sv
// character channel: one encoded ascii character per word
`default_nettype none

interface b64enc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

`default_nettype wire

// File: rtl/base64_stream_encoder.sv
// top level of the base64 stream encoder
//
//   port     dir  word             payload
//   byte_i   in   one raw byte     data_byte[7:0], last_byte
//   char_o   out  one ascii char   out_char[7:0], last_char
//
// bytes are taken one per cycle while the two-group queue has room
// each group of three bytes, or a shorter final group, leaves as four words
// the character output register holds a word while the receiver stalls, and
// the back end waits with it, while the queue keeps taking groups
// reset clears the held bytes, the queue pointers and all valid flags
`default_nettype none
`include "base64_stream_encoder_defines.svh"

module base64_stream_encoder (
  input  wire          clk_i,
  input  wire          rst_ni,
  b64enc_byte_if.sink  byte_i,
  b64enc_char_if.source char_o
);
  import b64enc_pkg::*;

  group_t  front_group;
  group_t  queue_group;
  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  logic    byte_acc;

  assign byte_acc = byte_i.valid & byte_i.ready;

  b64enc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_i),
    .q_stat_i (q_stat),
    .push_o   (q_push),
    .group_o  (front_group)
  );

  b64enc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .group_i  (front_group),
    .pop_i    (q_pop),
    .group_o  (queue_group),
    .q_stat_o (q_stat)
  );

  b64enc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .group_i  (queue_group),
    .q_stat_i (q_stat),
    .pop_o    (q_pop),
    .char_o   (char_o)
  );

  `B64E_ASSERT_NOW(a_no_push_full, q_push, !q_stat.full, "group pushed into full queue")
  `B64E_ASSERT_NOW(a_last_pushes, byte_acc && byte_i.last_byte, q_push, "final byte held")
  `B64E_ASSERT_NOW(a_stall_only_full, !byte_i.ready, q_stat.full, "byte stalled with queue room")
  `B64E_ASSERT_NEXT(a_push_not_empty, q_push && !q_pop, !q_stat.empty, "queue empty after a push")

endmodule

`default_nettype wire

// File: rtl/b64enc_front.sv
// front end: gathers bytes into groups of three, or a shorter final group, and queues them
`default_nettype none

module b64enc_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  b64enc_byte_if.sink          byte_i,
  input  b64enc_pkg::q_stat_t  q_stat_i,
  output logic                 push_o,
  output b64enc_pkg::group_t   group_o
);
  import b64enc_pkg::*;

  logic [15:0] held_q, held_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        accept;
  logic        full_group;

  assign byte_i.ready = ~q_stat_i.full;
  assign accept       = byte_i.valid & byte_i.ready;
  // a count of three cannot arise, it behaves as two
  assign full_group   = cnt_q[1];
  assign push_o       = accept & (full_group | byte_i.last_byte);

  always_comb begin
    group_o.fin = byte_i.last_byte;
    priority if (full_group) begin
      group_o.bits  = {held_q, byte_i.data_byte};
      group_o.n_pad = 2'd0;
    end else if (cnt_q == 2'd1) begin
      group_o.bits  = {held_q[7:0], byte_i.data_byte, 8'h00};
      group_o.n_pad = 2'd1;
    end else begin
      group_o.bits  = {byte_i.data_byte, 16'h0000};
      group_o.n_pad = 2'd2;
    end
  end

  always_comb begin
    held_d = held_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (push_o) begin
        held_d = '0;
        cnt_d  = '0;
      end else begin
        held_d = {held_q[7:0], byte_i.data_byte};
        cnt_d  = cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= '0;
    end else begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/b64enc_queue.sv
// short group queue between front and back
`default_nettype none

module b64enc_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  logic                 push_i,
  input  b64enc_pkg::group_t   group_i,
  input  logic                 pop_i,
  output b64enc_pkg::group_t   group_o,
  output b64enc_pkg::q_stat_t  q_stat_o
);
  import b64enc_pkg::*;

  group_t            entry_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign q_stat_o.full  = (cnt_q == QCntW'(QueueDepth));
  assign q_stat_o.empty = (cnt_q == '0);
  assign group_o        = entry_q[rd_ptr_q];

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    logic [QPtrW-1:0] r;
    if (p == QPtrW'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + QPtrW'(1);
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ptr_inc(wr_ptr_q);
    end
    if (pop_i) begin
      rd_ptr_d = ptr_inc(rd_ptr_q);
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + QCntW'(1);
      2'b01:   cnt_d = cnt_q - QCntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= group_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/b64enc_back.sv
// back end: turns each queued group into four characters
`default_nettype none

module b64enc_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  b64enc_pkg::group_t   group_i,
  input  b64enc_pkg::q_stat_t  q_stat_i,
  output logic                 pop_o,
  b64enc_char_if.source        char_o
);
  import b64enc_pkg::*;

  group_t      cur_q, cur_d;
  logic        cur_vld_q, cur_vld_d;
  logic [1:0]  idx_q, idx_d;
  logic        out_vld_q, out_vld_d;
  logic [7:0]  char_q, char_d;
  logic        last_q, last_d;
  logic        advance;
  logic        at_end;
  logic [5:0]  sextet;
  logic [2:0]  pad_sum;

  assign advance = cur_vld_q & (~out_vld_q | char_o.ready);
  assign at_end  = (idx_q == 2'd3);
  assign pop_o   = ~q_stat_i.empty & (~cur_vld_q | (advance & at_end));

  always_comb begin
    unique case (idx_q)
      2'd0: sextet = cur_q.bits[23:18];
      2'd1: sextet = cur_q.bits[17:12];
      2'd2: sextet = cur_q.bits[11:6];
      2'd3: sextet = cur_q.bits[5:0];
    endcase
  end

  // padding covers the tail positions once position plus pad count reaches four
  assign pad_sum = {1'b0, idx_q} + {1'b0, cur_q.n_pad};

  always_comb begin
    cur_d     = cur_q;
    cur_vld_d = cur_vld_q;
    idx_d     = idx_q;
    out_vld_d = out_vld_q;
    char_d    = char_q;
    last_d    = last_q;
    if (advance) begin
      out_vld_d = 1'b1;
      char_d    = pad_sum[2] ? PAD_CHAR : sextet_char(sextet);
      last_d    = cur_q.fin & at_end;
      idx_d     = idx_q + 2'd1;
      if (at_end) begin
        cur_vld_d = 1'b0;
      end
    end else if (char_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (pop_o) begin
      cur_d     = group_i;
      cur_vld_d = 1'b1;
      idx_d     = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign char_o.valid     = out_vld_q;
  assign char_o.out_char  = char_q;
  assign char_o.last_char = last_q;

endmodule

`default_nettype wire
